[rtl/antialiased_line_stepper_top_defines.svh]
// assertion macros for the antialiased line stepper
`ifndef ANTIALIASED_LINE_STEPPER_TOP_DEFINES_SVH
`define ANTIALIASED_LINE_STEPPER_TOP_DEFINES_SVH
`ifndef SYNTH
// condition must hold at every clock edge out of reset
`define ALS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("als check failed");
// consequence must hold in the cycle after the antecedent
`define ALS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("als check failed");
`else
`define ALS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ALS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/als_pkg.sv]
// types and constants shared across the antialiased line stepper
package als_pkg;

    localparam int COORD_W = 10;
    localparam int RGB_W   = 24;
    localparam int ERR_W   = 16;
    localparam int COV_W   = 8;
    localparam int STEPS_W = 11;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    // request action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [RGB_W-1:0]   pixel_rgb;
        logic [COV_W-1:0]   coverage;
        logic               is_partner;
        logic               last_pixel;
    } pix_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

[rtl/als_if.sv]
// request and pixel channel interfaces
interface als_req_if
    import als_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [RGB_W-1:0]   line_rgb;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, line_rgb,
        input  ready
    );
    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, line_rgb,
        output ready
    );
endinterface

interface als_pix_if
    import als_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [RGB_W-1:0]   pixel_rgb;
    logic [COV_W-1:0]   coverage;
    logic               is_partner;
    logic               last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_rgb, coverage, is_partner, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_rgb, coverage, is_partner, last_pixel,
        output ready
    );
endinterface

[rtl/als_divider.sv]
// radix-2 restoring divider for the error step, one quotient bit per cycle
`include "antialiased_line_stepper_top_defines.svh"

module als_divider
    import als_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic [COORD_W-1:0] minor,
    input  logic [COORD_W-1:0] major,
    output div_sts_t           sts,
    output logic [ERR_W-1:0]   quot
);

    localparam int CNT_W = $clog2(ERR_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] div_reg;
    logic [ERR_W-1:0]   quo_reg;

    logic [COORD_W:0]   rem_shift;
    logic [COORD_W:0]   rem_diff;
    logic               q_bit;
    logic [COORD_W-1:0] rem_next;

    // shift in a zero, subtract divisor if it fits
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, div_reg};
        q_bit     = (rem_shift >= {1'b0, div_reg});
        rem_next  = q_bit ? rem_diff[COORD_W-1:0] : rem_shift[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= minor;
            div_reg  <= major;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ERR_W-2:0], q_bit};
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ERR_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quo_reg;

    `ALS_ASSERT_NEXT(a_div_start_loads, clk, rst_n, ctl.start, busy_reg && cnt_reg == '0)
    `ALS_ASSERT_ALWAYS(a_div_rem_below_divisor, clk, rst_n, !busy_reg || rem_reg < div_reg)

endmodule

[rtl/antialiased_line_stepper_top.sv]
// top level of the antialiased line stepper: line setup, stepping and result buffer
//
// Walks an antialiased line (Wu style) one major-axis step per request and
// hands out pixels with an 8-bit coverage taken from a 16-bit error
// accumulator. A start request (action 0) clamps the endpoints to the
// screen, orders them top to bottom and puts the first pixel out in the
// next cycle; a single-point line comes out as one pixel marked last. Unless
// the line is diagonal or a single point, the error step (minor delta << 16)
// / major delta is then produced by a restoring divider at one bit per
// cycle, so the block takes no request after a start until the divide is
// done and the step is loaded. A step request (action 1) gives the pixel
// and, when it lands on screen, its partner (at column + direction on a
// row-major line, at row + 1 on a column-major one); a diagonal line gives
// one pixel per step with coverage 0. The request after the last interior
// pair returns the end pixel marked last; steps while no line is active
// give nothing. Results leave through a two-entry output buffer: a new
// request is taken in the same cycle that the last buffered result leaves,
// so a step is not taken while pixels of the one before (one or two) wait.
`include "antialiased_line_stepper_top_defines.svh"

module antialiased_line_stepper_top
    import als_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
)
(
    input  logic   clk,
    input  logic   rst_n,
    als_req_if.sink   req,
    als_pix_if.source pix
);

    // on-screen coordinate limits, never above the coordinate range
    localparam int COL_LIM_I = (SCREEN_WIDTH - 1 < int'(COORD_MAX)) ?
                               SCREEN_WIDTH - 1 : int'(COORD_MAX);
    localparam int ROW_LIM_I = (SCREEN_HEIGHT - 1 < int'(COORD_MAX)) ?
                               SCREEN_HEIGHT - 1 : int'(COORD_MAX);
    localparam logic [COORD_W-1:0] COL_LIMIT = COL_LIM_I[COORD_W-1:0];
    localparam logic [COORD_W-1:0] ROW_LIMIT = ROW_LIM_I[COORD_W-1:0];

    // line state
    logic               busy_reg,        busy_next;
    logic [COORD_W-1:0] cur_col_reg,     cur_col_next;
    logic [COORD_W-1:0] cur_row_reg,     cur_row_next;
    logic [COORD_W-1:0] end_col_reg,     end_col_next;
    logic [COORD_W-1:0] end_row_reg,     end_row_next;
    logic               col_dir_neg_reg, col_dir_neg_next;
    logic               row_major_reg,   row_major_next;
    logic               is_diag_reg,     is_diag_next;
    logic [ERR_W-1:0]   err_acc_reg,     err_acc_next;
    logic [ERR_W-1:0]   err_step_reg,    err_step_next;
    logic [STEPS_W-1:0] steps_left_reg,  steps_left_next;
    logic [RGB_W-1:0]   held_rgb_reg,    held_rgb_next;

    // two-entry result buffer: slot a is the head shown on the pixel channel
    pix_t slot_a_reg,  slot_a_next;
    pix_t slot_b_reg,  slot_b_next;
    logic valid_a_reg, valid_a_next;
    logic valid_b_reg, valid_b_next;

    // divider hookup
    div_ctl_t         div_ctl;
    div_sts_t         div_sts;
    logic [ERR_W-1:0] div_quot;

    logic take;
    logic pop;

    // start request decode
    logic [COORD_W-1:0] cx0, cy0, cx1, cy1;
    logic [COORD_W-1:0] sx0, sy0, sx1, sy1;
    logic               st_dir_neg;
    logic [COORD_W-1:0] st_dx, st_dy;
    logic               st_row_major;
    logic               st_diag;
    logic [COORD_W-1:0] st_major, st_minor;
    logic               st_single;

    // step datapath
    logic [ERR_W:0]     acc_sum;
    logic               carry;
    logic [COORD_W-1:0] col_moved;
    logic [COORD_W-1:0] new_col, new_row;
    logic [COORD_W:0]   part_col, part_row;
    logic               part_ok;

    assign take = req.valid && req.ready;
    assign pop  = pix.valid && pix.ready;

    // take a request once the divider is idle and the buffer drains
    assign req.ready = !div_sts.busy && !div_sts.done &&
                       (!valid_a_reg || (pop && !valid_b_reg));

    assign pix.valid      = valid_a_reg;
    assign pix.pixel_x    = slot_a_reg.pixel_x;
    assign pix.pixel_y    = slot_a_reg.pixel_y;
    assign pix.pixel_rgb  = slot_a_reg.pixel_rgb;
    assign pix.coverage   = slot_a_reg.coverage;
    assign pix.is_partner = slot_a_reg.is_partner;
    assign pix.last_pixel = slot_a_reg.last_pixel;

    // clamp, order top to bottom, find deltas and the major axis
    always_comb
    begin
        cx0 = (req.x_start > COL_LIMIT) ? COL_LIMIT : req.x_start;
        cx1 = (req.x_end   > COL_LIMIT) ? COL_LIMIT : req.x_end;
        cy0 = (req.y_start > ROW_LIMIT) ? ROW_LIMIT : req.y_start;
        cy1 = (req.y_end   > ROW_LIMIT) ? ROW_LIMIT : req.y_end;
        if (cy0 > cy1)
        begin
            sx0 = cx1; sy0 = cy1; sx1 = cx0; sy1 = cy0;
        end
        else
        begin
            sx0 = cx0; sy0 = cy0; sx1 = cx1; sy1 = cy1;
        end
        st_dir_neg   = (sx1 < sx0);
        st_dx        = st_dir_neg ? (sx0 - sx1) : (sx1 - sx0);
        st_dy        = sy1 - sy0;
        st_row_major = (st_dy > st_dx);
        st_diag      = (st_dx == st_dy) && (st_dx != '0);
        st_major     = st_row_major ? st_dy : st_dx;
        st_minor     = st_row_major ? st_dx : st_dy;
        st_single    = (st_major == '0);
    end

    // one step along the major axis, carry into the minor axis on wrap
    always_comb
    begin
        acc_sum   = {1'b0, err_acc_reg} + {1'b0, err_step_reg};
        carry     = acc_sum[ERR_W];
        col_moved = col_dir_neg_reg ? (cur_col_reg - COORD_W'(1))
                                    : (cur_col_reg + COORD_W'(1));
        if (is_diag_reg)
        begin
            new_col = col_moved;
            new_row = cur_row_reg + COORD_W'(1);
        end
        else if (row_major_reg)
        begin
            new_col = carry ? col_moved : cur_col_reg;
            new_row = cur_row_reg + COORD_W'(1);
        end
        else
        begin
            new_col = col_moved;
            new_row = cur_row_reg + COORD_W'(carry);
        end

        // partner sits beside the pixel across the minor axis
        if (row_major_reg)
        begin
            part_col = col_dir_neg_reg ? ({1'b0, new_col} - (COORD_W+1)'(1))
                                       : ({1'b0, new_col} + (COORD_W+1)'(1));
            part_row = {1'b0, new_row};
        end
        else
        begin
            part_col = {1'b0, new_col};
            part_row = {1'b0, new_row} + (COORD_W+1)'(1);
        end
        part_ok = !(row_major_reg && col_dir_neg_reg && (new_col == '0)) &&
                  (part_col <= {1'b0, COL_LIMIT}) &&
                  (part_row <= {1'b0, ROW_LIMIT});
    end

    always_comb
    begin
        busy_next        = busy_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        end_col_next     = end_col_reg;
        end_row_next     = end_row_reg;
        col_dir_neg_next = col_dir_neg_reg;
        row_major_next   = row_major_reg;
        is_diag_next     = is_diag_reg;
        err_acc_next     = err_acc_reg;
        err_step_next    = err_step_reg;
        steps_left_next  = steps_left_reg;
        held_rgb_next    = held_rgb_reg;
        slot_a_next      = slot_a_reg;
        slot_b_next      = slot_b_reg;
        valid_a_next     = valid_a_reg;
        valid_b_next     = valid_b_reg;
        div_ctl.start    = 1'b0;

        // buffer shifts toward the head as results leave
        if (pop)
        begin
            slot_a_next  = slot_b_reg;
            valid_a_next = valid_b_reg;
            valid_b_next = 1'b0;
        end

        if (take)
        begin
            if (req.action == ACT_START)
            begin
                // a start also drops any line in progress
                held_rgb_next    = req.line_rgb;
                col_dir_neg_next = st_dir_neg;
                row_major_next   = st_row_major;
                is_diag_next     = st_diag;
                cur_col_next     = sx0;
                cur_row_next     = sy0;
                end_col_next     = sx1;
                end_row_next     = sy1;
                err_acc_next     = '0;
                err_step_next    = '0;
                steps_left_next  = {1'b0, st_major} - STEPS_W'(1);
                busy_next        = !st_single;
                div_ctl.start    = !st_single && !st_diag;
                if (st_single)
                begin
                    steps_left_next = '0;
                end

                slot_a_next.pixel_x    = sx0;
                slot_a_next.pixel_y    = sy0;
                slot_a_next.pixel_rgb  = req.line_rgb;
                slot_a_next.coverage   = '0;
                slot_a_next.is_partner = 1'b0;
                slot_a_next.last_pixel = st_single;
                valid_a_next           = 1'b1;
                valid_b_next           = 1'b0;
            end
            else if (busy_reg)
            begin
                slot_a_next.pixel_rgb  = held_rgb_reg;
                slot_a_next.is_partner = 1'b0;
                valid_a_next           = 1'b1;
                valid_b_next           = 1'b0;
                if (steps_left_reg == '0)
                begin
                    // end pixel closes the line
                    busy_next              = 1'b0;
                    cur_col_next           = end_col_reg;
                    cur_row_next           = end_row_reg;
                    slot_a_next.pixel_x    = end_col_reg;
                    slot_a_next.pixel_y    = end_row_reg;
                    slot_a_next.coverage   = '0;
                    slot_a_next.last_pixel = 1'b1;
                end
                else
                begin
                    steps_left_next        = steps_left_reg - STEPS_W'(1);
                    cur_col_next           = new_col;
                    cur_row_next           = new_row;
                    slot_a_next.pixel_x    = new_col;
                    slot_a_next.pixel_y    = new_row;
                    slot_a_next.last_pixel = 1'b0;
                    if (is_diag_reg)
                    begin
                        slot_a_next.coverage = '0;
                    end
                    else
                    begin
                        err_acc_next           = acc_sum[ERR_W-1:0];
                        slot_a_next.coverage   = acc_sum[ERR_W-1:ERR_W-COV_W];
                        slot_b_next.pixel_x    = part_col[COORD_W-1:0];
                        slot_b_next.pixel_y    = part_row[COORD_W-1:0];
                        slot_b_next.pixel_rgb  = held_rgb_reg;
                        slot_b_next.coverage   = acc_sum[ERR_W-1:ERR_W-COV_W];
                        slot_b_next.is_partner = 1'b1;
                        slot_b_next.last_pixel = 1'b0;
                        valid_b_next           = part_ok;
                    end
                end
            end
        end

        // quotient lands before any step request can be taken
        if (div_sts.done)
        begin
            err_step_next = div_quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            end_col_reg     <= '0;
            end_row_reg     <= '0;
            col_dir_neg_reg <= 1'b0;
            row_major_reg   <= 1'b0;
            is_diag_reg     <= 1'b0;
            err_acc_reg     <= '0;
            err_step_reg    <= '0;
            steps_left_reg  <= '0;
            held_rgb_reg    <= '0;
            slot_a_reg      <= '0;
            slot_b_reg      <= '0;
            valid_a_reg     <= 1'b0;
            valid_b_reg     <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            end_col_reg     <= end_col_next;
            end_row_reg     <= end_row_next;
            col_dir_neg_reg <= col_dir_neg_next;
            row_major_reg   <= row_major_next;
            is_diag_reg     <= is_diag_next;
            err_acc_reg     <= err_acc_next;
            err_step_reg    <= err_step_next;
            steps_left_reg  <= steps_left_next;
            held_rgb_reg    <= held_rgb_next;
            slot_a_reg      <= slot_a_next;
            slot_b_reg      <= slot_b_next;
            valid_a_reg     <= valid_a_next;
            valid_b_reg     <= valid_b_next;
        end
    end

    als_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .minor (st_minor),
        .major (st_major),
        .sts   (div_sts),
        .quot  (div_quot)
    );

    `ALS_ASSERT_ALWAYS(a_partner_behind_head, clk, rst_n, !valid_b_reg || valid_a_reg)
    `ALS_ASSERT_ALWAYS(a_quot_for_live_line, clk, rst_n, !div_sts.done || (busy_reg && !is_diag_reg))
    `ALS_ASSERT_NEXT(a_start_gives_pixel, clk, rst_n, take && req.action == ACT_START, valid_a_reg)

endmodule

[verif/tb_antialiased_line_stepper_top.sv]
// self-checking testbench for the antialiased line stepper: directed table, random lines
`timescale 1ns / 1ps

module tb_antialiased_line_stepper_top;
    import als_pkg::*;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 1024;
    // endpoints are clamped to the screen and to the 10-bit coordinate range
    localparam int COL_LIMIT = (SCREEN_W - 1 < int'(COORD_MAX)) ? SCREEN_W - 1 : int'(COORD_MAX);
    localparam int ROW_LIMIT = (SCREEN_H - 1 < int'(COORD_MAX)) ? SCREEN_H - 1 : int'(COORD_MAX);

    localparam int REQUEST_TARGET = 820;    // result-producing requests before the run winds down
    localparam int CALM_FROM      = 450;    // both sides stop idling over this request window
    localparam int CALM_TO        = 600;
    localparam int HOLD_AT        = 250;    // request count at which the sink holds off
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PCT       = 23;
    localparam int DRAIN_CYCLES   = 40;     // divide, step load and output buffer, with margin
    localparam int CYCLE_LIMIT    = 400000;

    // how a directed row gets its expected pixels
    typedef enum int { EXP_PREDICT, EXP_NONE, EXP_TYPED } exp_kind_t;

    typedef struct {
        logic               act;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [RGB_W-1:0]   rgb;
        exp_kind_t          kind;
        pix_t               pix;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    als_req_if req_ch ();
    als_pix_if pix_ch ();

    antialiased_line_stepper_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .pix   (pix_ch)
    );

    // expected pixels, oldest first
    pix_t pixel_q [$];

    int  requests_done  = 0;   // accepted requests that produced at least one pixel
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    logic calm = 1'b0;         // no random idling on either side while set

    // line walker state, mirrors what the block holds between requests
    logic                line_busy;
    logic [COORD_W-1:0]  cur_col, cur_row, end_col, end_row;
    logic                col_neg, row_major, diag;
    logic [ERR_W-1:0]    err_acc, err_step;
    logic [STEPS_W-1:0]  steps_left;
    logic [RGB_W-1:0]    held_rgb;

    // directed part: extremes, off-screen partners, diagonal, restart while busy
    stim_row_t directed_rows [25] = '{
        // step with no line loaded gives nothing
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_NONE,    '0},
        // single point at the far corner: one pixel, marked last
        '{ACT_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF, EXP_TYPED,
          '{10'd1023, 10'd1023, 24'hFFFFFF, 8'd0, 1'b0, 1'b1}},
        '{ACT_STEP,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 24'hFFFFFF, EXP_NONE,    '0},
        // horizontal line along the top edge
        '{ACT_START, 10'd0,    10'd0,    10'd3,    10'd0,    24'h000001, EXP_TYPED,
          '{10'd0, 10'd0, 24'h000001, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd3, 10'd0, 24'h000001, 8'd0, 1'b0, 1'b1}},
        // horizontal on the bottom row: partner row falls off screen
        '{ACT_START, 10'd0,    10'd1023, 10'd2,    10'd1023, 24'h123456, EXP_TYPED,
          '{10'd0, 10'd1023, 24'h123456, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd2, 10'd1023, 24'h123456, 8'd0, 1'b0, 1'b1}},
        // vertical on the right edge, given bottom up: swapped, partner column off screen
        '{ACT_START, 10'd1023, 10'd2,    10'd1023, 10'd0,    24'hABCDEF, EXP_TYPED,
          '{10'd1023, 10'd0, 24'hABCDEF, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd1023, 10'd2, 24'hABCDEF, 8'd0, 1'b0, 1'b1}},
        // diagonal running left
        '{ACT_START, 10'd5,    10'd5,    10'd2,    10'd8,    24'h00FF00, EXP_TYPED,
          '{10'd5, 10'd5, 24'h00FF00, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd2, 10'd8, 24'h00FF00, 8'd0, 1'b0, 1'b1}},
        // full-screen diagonal, swapped, abandoned after one step
        '{ACT_START, 10'd1023, 10'd1023, 10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd0, 10'd0, 24'h000000, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        // restart while busy, steep line with a carry on the second step
        '{ACT_START, 10'd2,    10'd0,    10'd0,    10'd3,    24'h800000, EXP_TYPED,
          '{10'd2, 10'd0, 24'h800000, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_PREDICT, '0},
        '{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    24'h000000, EXP_TYPED,
          '{10'd0, 10'd3, 24'h800000, 8'd0, 1'b0, 1'b1}},
        // nearly vertical full-height line, small error step
        '{ACT_START, 10'd0,    10'd0,    10'd1,    10'd1023, 24'h7FFFFF, EXP_TYPED,
          '{10'd0, 10'd0, 24'h7FFFFF, 8'd0, 1'b0, 1'b0}},
        '{ACT_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  24'hFFFFFF, EXP_PREDICT, '0}
    };

    function automatic string pix_str(input pix_t p);
        return $sformatf("x=%0d y=%0d rgb=%06h cov=%0d partner=%0b last=%0b",
                         p.pixel_x, p.pixel_y, p.pixel_rgb, p.coverage,
                         p.is_partner, p.last_pixel);
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [COORD_W-1:0] col_step(input logic [COORD_W-1:0] c);
        return col_neg ? c - 10'd1 : c + 10'd1;
    endfunction

    // works out the pixels one accepted request gives and advances the walker state
    function automatic int trace_pixels(input logic act,
                                        input logic [COORD_W-1:0] xs, ys, xe, ye,
                                        input logic [RGB_W-1:0] rgb,
                                        output pix_t res [2]);
        logic [COORD_W-1:0] x0, y0, x1, y1, t, dx, dy;
        logic [ERR_W-1:0]   old_acc;
        logic [COV_W-1:0]   cov;
        logic               carry;
        int                 major, minor, px, py;
        res[0] = '0;
        res[1] = '0;
        if (act == ACT_START)
        begin
            x0 = (int'(xs) > COL_LIMIT) ? 10'(COL_LIMIT) : xs;
            x1 = (int'(xe) > COL_LIMIT) ? 10'(COL_LIMIT) : xe;
            y0 = (int'(ys) > ROW_LIMIT) ? 10'(ROW_LIMIT) : ys;
            y1 = (int'(ye) > ROW_LIMIT) ? 10'(ROW_LIMIT) : ye;
            // walk top to bottom
            if (y0 > y1)
            begin
                t = y0; y0 = y1; y1 = t;
                t = x0; x0 = x1; x1 = t;
            end
            held_rgb  = rgb;
            col_neg   = x1 < x0;
            dx        = col_neg ? x0 - x1 : x1 - x0;
            dy        = y1 - y0;
            cur_col   = x0;
            cur_row   = y0;
            end_col   = x1;
            end_row   = y1;
            err_acc   = '0;
            row_major = dy > dx;
            diag      = (dx == dy) && (dx != 0);
            major     = row_major ? int'(dy) : int'(dx);
            minor     = row_major ? int'(dx) : int'(dy);
            if (major == 0)
            begin
                err_step   = '0;
                steps_left = '0;
                line_busy  = 1'b0;
                res[0] = '{x0, y0, held_rgb, 8'd0, 1'b0, 1'b1};
                return 1;
            end
            err_step   = diag ? '0 : 16'((minor << 16) / major);
            steps_left = 11'(major - 1);
            line_busy  = 1'b1;
            res[0] = '{x0, y0, held_rgb, 8'd0, 1'b0, 1'b0};
            return 1;
        end
        if (!line_busy)
            return 0;
        if (steps_left == 0)
        begin
            line_busy = 1'b0;
            cur_col   = end_col;
            cur_row   = end_row;
            res[0] = '{end_col, end_row, held_rgb, 8'd0, 1'b0, 1'b1};
            return 1;
        end
        steps_left = steps_left - 11'd1;
        if (diag)
        begin
            cur_row = cur_row + 10'd1;
            cur_col = col_step(cur_col);
            res[0] = '{cur_col, cur_row, held_rgb, 8'd0, 1'b0, 1'b0};
            return 1;
        end
        old_acc = err_acc;
        err_acc = err_acc + err_step;
        carry   = err_acc < old_acc;
        if (row_major)
        begin
            cur_row = cur_row + 10'd1;
            if (carry)
                cur_col = col_step(cur_col);
            px = int'(cur_col) + (col_neg ? -1 : 1);
            py = int'(cur_row);
        end
        else
        begin
            cur_col = col_step(cur_col);
            if (carry)
                cur_row = cur_row + 10'd1;
            px = int'(cur_col);
            py = int'(cur_row) + 1;
        end
        cov = err_acc[ERR_W-1:8];
        res[0] = '{cur_col, cur_row, held_rgb, cov, 1'b0, 1'b0};
        // partner is dropped when it lands off screen
        if (px < 0 || px >= SCREEN_W || px > int'(COORD_MAX) ||
            py >= SCREEN_H || py > int'(COORD_MAX))
            return 1;
        res[1] = '{10'(px), 10'(py), held_rgb, cov, 1'b1, 1'b0};
        return 2;
    endfunction

    // offers one request, waits for it to be taken, then queues its expected pixels
    task automatic send_request(input logic act, input logic [COORD_W-1:0] xs, ys, xe, ye,
                                input logic [RGB_W-1:0] rgb, input exp_kind_t kind,
                                input pix_t typed);
        pix_t res [2];
        int   n;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.x_start  <= xs;
        req_ch.y_start  <= ys;
        req_ch.x_end    <= xe;
        req_ch.y_end    <= ye;
        req_ch.line_rgb <= rgb;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n = trace_pixels(act, xs, ys, xe, ye, rgb, res);
        if (n > 0)
            requests_done++;
        calm = (requests_done >= CALM_FROM) && (requests_done < CALM_TO);
        if (kind == EXP_TYPED)
            pixel_q.push_back(typed);
        else if (kind == EXP_PREDICT)
        begin
            for (int k = 0; k < n; k++)
                pixel_q.push_back(res[k]);
        end
    endtask

    // random coordinate, biased toward the screen edges
    function automatic logic [COORD_W-1:0] pick_coord();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return COORD_MAX;
        return 10'($urandom);
    endfunction

    // coordinate a short distance from v, saturated to the screen
    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(24)) - 12;
        if (t < 0)
            t = 0;
        if (t > int'(COORD_MAX))
            t = int'(COORD_MAX);
        return 10'(t);
    endfunction

    // pixel sink: random back-pressure, one long hold-off, checks every accepted pixel
    initial
    begin : pixel_sink
        pix_t got;
        pix_t want;
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pix_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_ch.valid && pix_ch.ready)
            begin
                got = '{pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_rgb, pix_ch.coverage,
                        pix_ch.is_partner, pix_ch.last_pixel};
                if (pixel_q.size() == 0)
                    report_error({"unexpected pixel: ", pix_str(got)});
                else
                begin
                    want = pixel_q.pop_front();
                    if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                        got.pixel_rgb !== want.pixel_rgb || got.coverage !== want.coverage ||
                        got.is_partner !== want.is_partner ||
                        got.last_pixel !== want.last_pixel)
                        report_error({"pixel mismatch\n  expected: ", pix_str(want),
                                      "\n  actual:   ", pix_str(got)});
                end
            end
            // one long stall so the output buffer fills and the request side backs up
            if (!hold_done && requests_done >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end
            else
                pix_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // stimulus and end of run
    initial
    begin : stimulus
        logic [COORD_W-1:0] xs, ys, xe, ye;
        int                 roll, n_steps;
        logic               long_line;
        line_busy  = 1'b0;
        cur_col    = '0;
        cur_row    = '0;
        end_col    = '0;
        end_row    = '0;
        col_neg    = 1'b0;
        row_major  = 1'b0;
        diag       = 1'b0;
        err_acc    = '0;
        err_step   = '0;
        steps_left = '0;
        held_rgb   = '0;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_STEP;
        req_ch.x_start  <= '0;
        req_ch.y_start  <= '0;
        req_ch.x_end    <= '0;
        req_ch.y_end    <= '0;
        req_ch.line_rgb <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].xs, directed_rows[i].ys,
                         directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].rgb,
                         directed_rows[i].kind, directed_rows[i].pix);

        // random lines: mostly a start followed by its full run of steps
        while (requests_done < REQUEST_TARGET)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
            begin
                // noise: anything at all
                send_request(1'($urandom_range(1)), 10'($urandom), 10'($urandom),
                             10'($urandom), 10'($urandom), 24'($urandom), EXP_PREDICT, '0);
            end
            else
            begin
                long_line = $urandom_range(9) == 0;
                xs = pick_coord();
                ys = pick_coord();
                xe = long_line ? pick_coord() : near_coord(xs);
                ye = long_line ? pick_coord() : near_coord(ys);
                send_request(ACT_START, xs, ys, xe, ye, 24'($urandom), EXP_PREDICT, '0);
                n_steps = line_busy ? int'(steps_left) + 1 : 0;
                if (long_line && n_steps > 40)
                    n_steps = $urandom_range(40, 1);
                else if (n_steps > 0 && $urandom_range(9) == 0)
                    n_steps = $urandom_range(n_steps - 1);   // abandoned by the next start
                else
                    n_steps += $urandom_range(2) == 0 ? $urandom_range(2) : 0;  // extra steps idle
                for (int s = 0; s < n_steps; s++)
                    send_request(ACT_STEP, 10'($urandom), 10'($urandom), 10'($urandom),
                                 10'($urandom), 24'($urandom), EXP_PREDICT, '0);
            end
        end
        req_ch.valid <= 1'b0;

        while (pixel_q.size() != 0)
            @(posedge clk);
        // anything the block still puts out now is unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pixel_q.size() != 0)
            report_error($sformatf("%0d expected pixels never arrived", pixel_q.size()));

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
